[rtl/fdl_pkg.sv]
// ============================================================================
// fdl_pkg
// Shared constants for the feedback delay line: field widths and gain scale.
// ============================================================================
package fdl_pkg;

    localparam int DELAY_BITS = 16;
    localparam int GAIN_BITS  = 16;
    localparam int FRAC_BITS  = 15;

    // unsigned Q1.15 unity gain
    localparam logic [GAIN_BITS-1:0] GAIN_ONE = 16'h8000;

endpackage

[rtl/fdl_if.sv]
// ============================================================================
// fdl_if
// Valid/ready channels of the feedback delay line: sample in, echo out.
// ============================================================================
interface fdl_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                              valid;
    logic                              ready;
    logic signed [SAMPLE_BITS-1:0]     sample_in;
    logic [fdl_pkg::DELAY_BITS-1:0]    delay_samples;
    logic [fdl_pkg::GAIN_BITS-1:0]     feedback_gain;

    modport source (output valid, sample_in, delay_samples, feedback_gain, input ready);
    modport sink   (input valid, sample_in, delay_samples, feedback_gain, output ready);
endinterface

interface fdl_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] delayed_sample;

    modport source (output valid, delayed_sample, input ready);
    modport sink   (input valid, delayed_sample, output ready);
endinterface

[rtl/feedback_delay_line_core.sv]
// ============================================================================
// feedback_delay_line_core
// Echo over a circular sample store: returns the sample at the delay tap and
// writes back the feedback mix of the new sample and the tap value.
//
//   channel  dir  fields                                       handshake
//   smp      in   sample_in, delay_samples, feedback_gain      valid/ready
//   echo     out  delayed_sample                               valid/ready
//
// One item per cycle unless stalled; each item passes the stage 1 and stage 2
// registers. Stages: store read at accept, tap select and two gain products,
// mix and write back. A delay of one sample against the item right ahead
// holds smp.ready low while that item is in stage 1 (the tap is not computed
// yet); the last write is forwarded. Reset needs no clearing pass: a write
// pointer plus wrap flag mark entries never written, which read as zero.
// A stalled echo output holds the whole pipeline and smp.ready.
// ============================================================================
module feedback_delay_line_core #(
    parameter int DEPTH       = 32768,
    parameter int SAMPLE_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    fdl_in_if.sink    smp,
    fdl_out_if.source echo
);

    localparam int AW = $clog2(DEPTH);
    localparam int DW = (AW + 1 > fdl_pkg::DELAY_BITS) ? AW + 1 : fdl_pkg::DELAY_BITS;
    localparam int PW = SAMPLE_BITS + fdl_pkg::GAIN_BITS + 1;
    localparam int SW = PW + 1;

    localparam logic [AW-1:0]        WP_LAST = AW'(DEPTH - 1);
    localparam logic [DW-1:0]        DEPTH_D = DW'(DEPTH);
    localparam logic [DW:0]          DEPTH_T = (DW + 1)'(DEPTH);
    localparam logic signed [SW-1:0] SMAX    = (SW'(1) <<< (SAMPLE_BITS - 1)) - SW'(1);
    localparam logic signed [SW-1:0] SMIN    = -SMAX - SW'(1);

    logic [SAMPLE_BITS-1:0] mem [DEPTH];

    // control
    logic          v1_reg, v2_reg;
    logic [AW-1:0] wp_reg;
    logic          full_reg;
    logic          lw_valid_reg;

    // payload
    logic [AW-1:0]                   wp1_reg, tap1_reg, wp2_reg, lw_addr_reg;
    logic signed [SAMPLE_BITS-1:0]   s1_reg, rdata_reg, tv2_reg, lw_data_reg;
    logic [fdl_pkg::GAIN_BITS-1:0]   fb1_reg;
    logic                            zero1_reg;
    logic signed [PW-1:0]            pa2_reg, pb2_reg;

    logic                            adv, hazard, accept, we;
    logic [DW-1:0]                   d_ext, d_sat;
    logic [DW:0]                     diff, tap_t;
    logic [AW-1:0]                   tap, wp_next;
    logic [fdl_pkg::GAIN_BITS-1:0]   fb_sat, one_m;
    logic                            unwritten;
    logic signed [SAMPLE_BITS-1:0]   tv1;
    logic signed [PW-1:0]            ga_ext, gb_ext, s_ext, t_ext, pa_next, pb_next;
    logic signed [SW-1:0]            sum, shifted;
    logic signed [SAMPLE_BITS-1:0]   nv;

    // ---- stage 0: tap address, interlock, read issue
    always_comb
    begin
        d_ext     = DW'(smp.delay_samples);
        d_sat     = (d_ext > DEPTH_D) ? DEPTH_D : d_ext;
        diff      = {1'b0, DW'(wp_reg)} - {1'b0, d_sat};
        tap_t     = diff[DW] ? diff + DEPTH_T : diff;
        tap       = tap_t[AW-1:0];
        unwritten = !full_reg && !(tap < wp_reg);
        fb_sat    = (smp.feedback_gain > fdl_pkg::GAIN_ONE) ? fdl_pkg::GAIN_ONE
                                                             : smp.feedback_gain;
        wp_next   = (wp_reg == WP_LAST) ? '0 : wp_reg + 1'b1;
        adv       = !v2_reg || echo.ready;
        hazard    = v1_reg && (tap == wp1_reg);
    end

    assign smp.ready = adv && !hazard;
    assign accept    = smp.valid && smp.ready;

    // ---- stage 1: tap select with forwarding, gain products
    always_comb
    begin
        if (lw_valid_reg && (lw_addr_reg == tap1_reg))
        begin
            tv1 = lw_data_reg;
        end
        else if (zero1_reg)
        begin
            tv1 = '0;
        end
        else
        begin
            tv1 = rdata_reg;
        end
        one_m   = fdl_pkg::GAIN_ONE - fb1_reg;
        ga_ext  = PW'($signed({1'b0, one_m}));
        gb_ext  = PW'($signed({1'b0, fb1_reg}));
        s_ext   = PW'(s1_reg);
        t_ext   = PW'(tv1);
        pa_next = ga_ext * s_ext;
        pb_next = gb_ext * t_ext;
    end

    // ---- stage 2: mix, floor, saturate, write back
    always_comb
    begin
        sum     = SW'(pa2_reg) + SW'(pb2_reg);
        shifted = sum >>> fdl_pkg::FRAC_BITS;
        if (shifted > SMAX)
        begin
            nv = SMAX[SAMPLE_BITS-1:0];
        end
        else if (shifted < SMIN)
        begin
            nv = SMIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            nv = shifted[SAMPLE_BITS-1:0];
        end
    end

    assign we                  = adv && v2_reg;
    assign echo.valid          = v2_reg;
    assign echo.delayed_sample = tv2_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wp2_reg] <= nv;
        end
        if (accept)
        begin
            rdata_reg <= mem[tap];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            wp_reg       <= '0;
            full_reg     <= 1'b0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                v1_reg <= accept;
                v2_reg <= v1_reg;
            end
            if (accept)
            begin
                wp_reg <= wp_next;
                if (wp_reg == WP_LAST)
                begin
                    full_reg <= 1'b1;
                end
            end
            if (we)
            begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wp1_reg   <= wp_reg;
            tap1_reg  <= tap;
            s1_reg    <= smp.sample_in;
            fb1_reg   <= fb_sat;
            zero1_reg <= unwritten;
        end
        if (adv)
        begin
            wp2_reg <= wp1_reg;
            tv2_reg <= tv1;
            pa2_reg <= pa_next;
            pb2_reg <= pb_next;
        end
        if (we)
        begin
            lw_addr_reg <= wp2_reg;
            lw_data_reg <= nv;
        end
    end

    // ---- checks
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (smp.valid && smp.ready) |=> v1_reg)
        else $error("accepted item did not enter stage 1");

    a_write_order: assert property (@(posedge clk) disable iff (!rst_n)
        (we && lw_valid_reg) |->
            (wp2_reg == ((lw_addr_reg == WP_LAST) ? '0 : lw_addr_reg + 1'b1)))
        else $error("store writes out of pointer order");

    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |=> full_reg)
        else $error("wrap flag cleared");

    a_no_tap_race: assert property (@(posedge clk) disable iff (!rst_n)
        (smp.valid && smp.ready && v1_reg) |-> (tap != wp1_reg))
        else $error("read of an entry still being computed");

endmodule

[tb/testbench.sv]
// ============================================================================
// testbench
// Self-checking bench for feedback_delay_line_core. A behavioral copy of the
// echo store predicts every delayed_sample; each output item is checked in
// order against it. Covers field extremes, short delays against the items in
// flight, long output stalls, long taps onto cleared entries, and random
// traffic with bursty input and a stalling output.
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 32768;
    localparam int SAMPLE_BITS = 16;
    localparam int IDLE_LIMIT  = 4000;

    logic clk;
    logic rst_n;

    fdl_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) smp_if ();
    fdl_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) echo_if ();

    feedback_delay_line_core #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .smp   (smp_if.sink),
        .echo  (echo_if.source)
    );

    // echo store copy and expected outputs
    logic signed [SAMPLE_BITS-1:0] echo_store [0:DEPTH-1];
    logic [14:0]                   write_ptr;
    logic signed [SAMPLE_BITS-1:0] echo_expected [$];

    int errors;
    int burst_left;
    int hold_left;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // returns the tap value and writes back the feedback mix
    function automatic logic signed [SAMPLE_BITS-1:0] echo_step(
        input logic signed [SAMPLE_BITS-1:0]  s,
        input logic [fdl_pkg::DELAY_BITS-1:0] d,
        input logic [fdl_pkg::GAIN_BITS-1:0]  g
    );
        logic [fdl_pkg::DELAY_BITS-1:0] dly;
        logic [fdl_pkg::GAIN_BITS-1:0]  gain;
        logic [14:0]                    tap;
        logic signed [SAMPLE_BITS-1:0]  tv;
        longint                         sum;
        longint                         mixed;
        begin
            dly  = (d > DEPTH) ? fdl_pkg::DELAY_BITS'(DEPTH) : d;
            gain = (g > fdl_pkg::GAIN_ONE) ? fdl_pkg::GAIN_ONE : g;
            tap  = write_ptr - dly[14:0];
            tv   = echo_store[tap];
            sum  = (longint'(fdl_pkg::GAIN_ONE) - longint'(gain)) * longint'(s)
                 + longint'(gain) * longint'(tv);
            mixed = sum >>> fdl_pkg::FRAC_BITS;
            if (mixed > 32767)
                mixed = 32767;
            else if (mixed < -32768)
                mixed = -32768;
            echo_store[write_ptr] = mixed[SAMPLE_BITS-1:0];
            write_ptr = write_ptr + 15'd1;
            return tv;
        end
    endfunction

    // entered and left at a falling edge
    task automatic send_sample(input int s, input int d, input int g);
        int gap;
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 48);
                gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
                if (gap > 0)
                begin
                    smp_if.valid = 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            smp_if.valid         = 1'b1;
            smp_if.sample_in     = s[SAMPLE_BITS-1:0];
            smp_if.delay_samples = d[fdl_pkg::DELAY_BITS-1:0];
            smp_if.feedback_gain = g[fdl_pkg::GAIN_BITS-1:0];
            @(posedge clk);
            while (!smp_if.ready)
                @(posedge clk);
            echo_expected.push_back(echo_step(smp_if.sample_in, smp_if.delay_samples,
                                              smp_if.feedback_gain));
            burst_left = burst_left - 1;
            @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        begin
            smp_if.valid = 1'b0;
            while (echo_expected.size() != 0)
                @(negedge clk);
        end
    endtask

    function automatic int rand_delay();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(1, 8);
            6:                return ($urandom_range(0, 1) == 0) ? 0 : DEPTH;
            7:                return $urandom_range(9, 2000);
            8:                return $urandom_range(0, 65535);
            default:          return $urandom_range(DEPTH + 1, 65535);
        endcase
    endfunction

    function automatic int rand_gain();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return int'(fdl_pkg::GAIN_ONE);
            2:       return $urandom_range(32769, 65535);
            3:       return $urandom_range(0, 65535);
            default: return $urandom_range(0, 32768);
        endcase
    endfunction

    function automatic int rand_sample();
        case ($urandom_range(0, 9))
            0:       return 32767;
            1:       return -32768;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic test_corner_cases();
        begin
            send_sample(32767, 1, 0);
            send_sample(-32768, 1, 0);
            send_sample(-32768, 1, int'(fdl_pkg::GAIN_ONE));
            send_sample(12345, 1, 65535);
            send_sample(-1, 2, 16384);
            send_sample(1, 3, 16384);
            send_sample(-3, 1, 1);
            send_sample(0, 0, 0);
            send_sample(7, DEPTH, 100);
            send_sample(-7, 65535, 32767);
            send_sample(21845, 4, 1);
            send_sample(-21846, 1, 32767);
            send_sample(32767, 2, int'(fdl_pkg::GAIN_ONE));
            send_sample(-32768, 5, 65535);
            send_sample(-2, 1, 32769);
            send_sample(100, DEPTH + 1, 0);
            send_sample(-100, 1, 16384);
            send_sample(32767, 3, 10922);
            send_sample(-32768, 2, 21845);
            send_sample(1, 1, 32767);
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        begin
            hold_left = 300;
            repeat (40)
                send_sample(rand_sample(), $urandom_range(1, 4), rand_gain());
            wait_drained();
            repeat (30)
                send_sample(rand_sample(), $urandom_range(1, 3), rand_gain());
            wait_drained();
        end
    endtask

    // taps that reach back past the first write land on cleared entries
    task automatic test_long_taps();
        begin
            repeat (16)
                send_sample(rand_sample(), rand_delay(), rand_gain());
            send_sample(5, 0, 0);
            send_sample(-5, DEPTH, int'(fdl_pkg::GAIN_ONE));
            send_sample(9, 65535, 16384);
            send_sample(-9, DEPTH - 1, 100);
            wait_drained();
        end
    endtask

    task automatic test_random_echo();
        begin
            repeat (1340)
            begin
                send_sample(rand_sample(), rand_delay(), rand_gain());
                if ($urandom_range(0, 299) == 0)
                    hold_left = $urandom_range(50, 250);
            end
            wait_drained();
        end
    endtask

    // output stall pattern
    int stall_mode;
    int phase_left;
    int ready_cnt;

    initial
    begin
        stall_mode    = 0;
        phase_left    = 0;
        ready_cnt     = 0;
        echo_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                echo_if.ready = 1'b0;
                hold_left = hold_left - 1;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    phase_left = $urandom_range(20, 200);
                    stall_mode = $urandom_range(0, 3);
                end
                phase_left = phase_left - 1;
                ready_cnt  = ready_cnt + 1;
                case (stall_mode)
                    0:       echo_if.ready = 1'b1;
                    1:       echo_if.ready = ($urandom_range(0, 1) == 1);
                    2:       echo_if.ready = ($urandom_range(0, 3) == 0);
                    default: echo_if.ready = ((ready_cnt % 8) < 5);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && echo_if.valid && echo_if.ready)
        begin
            if (echo_expected.size() == 0)
            begin
                $display("%0t: unexpected item, delayed_sample %0d", $time,
                         echo_if.delayed_sample);
                errors = errors + 1;
            end
            else
            begin
                logic signed [SAMPLE_BITS-1:0] exp_val;
                exp_val = echo_expected.pop_front();
                if (echo_if.delayed_sample !== exp_val)
                begin
                    $display("%0t: delayed_sample mismatch, expected %0d, actual %0d",
                             $time, exp_val, echo_if.delayed_sample);
                    errors = errors + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (smp_if.valid && smp_if.ready) || (echo_if.valid && echo_if.ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        errors               = 0;
        burst_left           = 0;
        hold_left            = 0;
        idle_cycles          = 0;
        write_ptr            = '0;
        rst_n                = 1'b0;
        smp_if.valid         = 1'b0;
        smp_if.sample_in     = '0;
        smp_if.delay_samples = '0;
        smp_if.feedback_gain = '0;
        for (int i = 0; i < DEPTH; i++)
            echo_store[i] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_corner_cases();
        test_backpressure();
        test_long_taps();
        test_random_echo();

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[feedback_delay_line_core.f]
rtl/fdl_pkg.sv
rtl/fdl_if.sv
rtl/feedback_delay_line_core.sv
tb/testbench.sv
